/* rtl/core/lmcf_pkg.sv */
// ----------------------------------------------------------------------------
// lmcf_pkg
// Shared types and codes for the LED matrix column framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmcf_pkg;

  localparam int unsigned NumCols = 8;

  typedef logic [7:0] byte_t;
  typedef logic [NumCols-1:0][7:0] bytes8_t;

  typedef enum logic [1:0] {
    ORIENT_TRANSPOSE = 2'd0,
    ORIENT_DIRECT    = 2'd1,
    ORIENT_MIRROR    = 2'd2,
    ORIENT_REVERSE   = 2'd3
  } orient_t;

  typedef enum logic [1:0] {
    REG_CHAIN_LENGTH = 2'd0,
    REG_ORIENTATION  = 2'd1,
    REG_INVERT       = 2'd2
  } cfg_reg_t;

  localparam logic [3:0] REG_ADDR_NOOP = 4'd0;
  localparam byte_t      DATA_NOOP     = 8'h00;

  // One module's worth of work, as handed to the word emitter
  typedef struct packed {
    bytes8_t    cols;   // column bytes, index = column
    logic [2:0] chip;   // no-op words before the target word
    logic [2:0] trail;  // no-op words after the target word
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/lmcf_lane.sv */
// ----------------------------------------------------------------------------
// lmcf_lane
// Builds the byte of one fixed column from the eight pixel bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcf_lane
  import lmcf_pkg::*;
#(
  parameter int unsigned COL = 0
) (
  input  var bytes8_t    px,
  input  var orient_t    orientation,
  input  var logic       invert,
  output var byte_t      col_byte
);

  localparam int unsigned MirCol = 7 - COL;

  byte_t b;

  always_comb begin
    b = '0;
    case (orientation)
      ORIENT_TRANSPOSE: begin
        for (int i = 0; i < 8; i++) b[7-i] = px[i][COL];
      end
      ORIENT_DIRECT: b = px[COL];
      ORIENT_MIRROR: begin
        for (int i = 0; i < 8; i++) b[i] = px[i][MirCol];
      end
      ORIENT_REVERSE: b = px[MirCol];
      default: b = '0;
    endcase
  end

  assign col_byte = invert ? ~b : b;

endmodule

`default_nettype wire

/* rtl/core/lmcf_emit.sv */
// ----------------------------------------------------------------------------
// lmcf_emit
// Merging stage: walks columns and frame positions, one word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lmcf_emit
  import lmcf_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       pend_valid,
  input  var item_t      pend,
  output var logic       take,
  output var logic       out_valid,
  input  var logic       out_stall,
  output var logic [3:0] reg_addr,
  output var byte_t      data_byte,
  output var logic       frame_end,
  output var logic       last
);

  logic       busy;
  item_t      act;
  logic [2:0] col;
  logic [2:0] pos;

  logic       advance;
  logic [2:0] flast;
  logic       fe_word;
  logic       final_word;

  assign flast      = act.chip + act.trail;
  assign fe_word    = (pos == flast);
  assign final_word = fe_word && (col == 3'd7);
  assign advance    = busy && (!out_valid || !out_stall);
  assign take       = pend_valid && (!busy || (advance && final_word));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      col       <= '0;
      pos       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (pos == act.chip) begin
          reg_addr  <= {1'b0, col} + 4'd1;
          data_byte <= act.cols[col];
        end else begin
          reg_addr  <= REG_ADDR_NOOP;
          data_byte <= DATA_NOOP;
        end
        frame_end <= fe_word;
        last      <= final_word;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      // load the next item right behind the final word
      if (take) begin
        busy <= 1'b1;
        act  <= pend;
        pos  <= '0;
        col  <= '0;
      end else if (advance) begin
        if (final_word) begin
          busy <= 1'b0;
        end else if (fe_word) begin
          pos <= '0;
          col <= col + 3'd1;
        end else begin
          pos <= pos + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/led_matrix_column_framer.sv */
// An item passes the input holding register and the emitter's item register
// before its words are registered at the output. An item is 8 * F words, F =
// max(min(chain_length, MAX_CHAIN), chip_index + 1), at most 64; one word per
// cycle unless stalled. The next item is held and follows with no gap.
// Reset: chain_length 4, orientation 0, invert 0, no item held, output empty.
// ----------------------------------------------------------------------------
// led_matrix_column_framer
// Reorients one 8x8 module bitmap in eight column lanes and sends daisy-chain
// frames of register words, one per column.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_column_framer
  import lmcf_pkg::*;
#(
  parameter int unsigned MAX_CHAIN = 8
) (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       cfg_write,
  input  var logic [1:0] cfg_index,
  input  var logic [3:0] cfg_data,
  input  var logic       in_valid,
  output var logic       in_stall,
  input  var logic [2:0] chip_index,
  input  var logic [7:0] pixel_0,
  input  var logic [7:0] pixel_1,
  input  var logic [7:0] pixel_2,
  input  var logic [7:0] pixel_3,
  input  var logic [7:0] pixel_4,
  input  var logic [7:0] pixel_5,
  input  var logic [7:0] pixel_6,
  input  var logic [7:0] pixel_7,
  output var logic       out_valid,
  input  var logic       out_stall,
  output var logic [3:0] reg_addr,
  output var logic [7:0] data_byte,
  output var logic       frame_end,
  output var logic       last
);

  localparam logic [3:0] MaxLen = 4'(MAX_CHAIN);

  logic [3:0] chain_length;
  orient_t    orientation;
  logic       invert;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= 4'd4;
      orientation  <= ORIENT_TRANSPOSE;
      invert       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHAIN_LENGTH: chain_length <= cfg_data;
        REG_ORIENTATION:  orientation  <= orient_t'(cfg_data[1:0]);
        REG_INVERT:       invert       <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // column lanes
  bytes8_t px;
  bytes8_t cols;

  assign px = {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};

  for (genvar c = 0; c < NumCols; c++) begin : g_lane
    lmcf_lane #(.COL(c)) u_lane (
      .px          (px),
      .orientation (orientation),
      .invert      (invert),
      .col_byte    (cols[c])
    );
  end

  // trailing no-op count
  logic [3:0] len;
  logic [3:0] chip_p1;
  logic [3:0] trail_w;

  assign len     = (chain_length > MaxLen) ? MaxLen : chain_length;
  assign chip_p1 = {1'b0, chip_index} + 4'd1;
  assign trail_w = (len > chip_p1) ? (len - chip_p1) : 4'd0;

  // input holding register
  logic  pend_valid;
  item_t pend;
  logic  take;
  logic  accept;

  assign in_stall = pend_valid;
  assign accept   = in_valid && !pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend.cols  <= cols;
      pend.chip  <= chip_index;
      pend.trail <= trail_w[2:0];
    end
  end

  lmcf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_addr   (reg_addr),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .last       (last)
  );

endmodule

`default_nettype wire
